[sv/nwtt_pkg.sv]
package nwtt_pkg;

	// Action codes of an input item.
	localparam logic ACT_MAP   = 1'b0;
	localparam logic ACT_XLATE = 1'b1;

	// Status codes of a result item.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOMATCH = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	// One input item.
	typedef struct packed {
		logic        action;
		logic [31:0] key_ip;
		logic        key_ip_any;
		logic [15:0] key_port;
		logic        key_port_any;
		logic [31:0] new_ip;
		logic [15:0] new_port;
	} nat_req_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_ip;
		logic [15:0] result_port;
	} nat_rsp_t;

	// Translated address and port of a rule.
	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] port;
	} nat_target_t;

	// One stored rule: key and target.
	typedef struct packed {
		logic [31:0] ip;
		logic        ip_wild;
		logic [15:0] port;
		logic        port_wild;
		nat_target_t target;
	} nat_rule_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} nwtt_state_t;

endpackage

[sv/nat_wildcard_translation_table.sv]
// Each item's result strobe (done) follows one pass over the rule memory through its
// single read port, one entry per cycle, then the drain and finish (decide/write) states.
// Busy stays high until done rises, so no new item is accepted while one is in flight.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset empties the table at once (rule count to zero); no clearing pass.
module nat_wildcard_translation_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  nwtt_pkg::nat_req_t cmd,
	output logic               done,
	output nwtt_pkg::nat_rsp_t result
);
	import nwtt_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	nwtt_state_t state_q, state_d;
	nat_req_t    req_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] cmp_idx_s1;
	logic          cmp_vld_s1;
	logic [CW-1:0] count_q;

	logic          key_hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          ip_seen_q, exact_hit_q, anyport_hit_q, anyip_hit_q;
	nat_target_t   exact_tgt_q, anyport_tgt_q, anyip_tgt_q;

	logic      done_q;
	nat_rsp_t  result_q;

	logic          accept;
	logic          last_read;
	nat_rule_t     rdata;
	logic          entry_vld;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	nat_rule_t     mem_wdata;
	logic          count_inc;
	nat_rsp_t      result_d;
	nat_req_t      req_norm;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign last_read = (rd_idx_q == IW'(TABLE_ENTRIES - 1));
	assign done      = done_q;
	assign result    = result_q;

	// Rule storage.
	nwtt_rule_mem #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	// A map key stores a wildcard part as zero; a translate query is kept raw.
	always_comb begin
		req_norm = cmd;
		if (cmd.action == ACT_MAP) begin
			if (cmd.key_ip_any) begin
				req_norm.key_ip = '0;
			end
			if (cmd.key_port_any) begin
				req_norm.key_port = '0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_read) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: table write and result in the final state.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		count_inc = 1'b0;
		result_d  = '{status: STATUS_NOMATCH, result_ip: '0, result_port: '0};
		mem_wdata = '{
			ip:        req_q.key_ip,
			ip_wild:   req_q.key_ip_any,
			port:      req_q.key_port,
			port_wild: req_q.key_port_any,
			target:    '{ip: req_q.new_ip, port: req_q.new_port}
		};
		case (state_q)
			ST_FINISH: begin
				if (req_q.action == ACT_MAP) begin
					if (key_hit_q) begin
						mem_we          = 1'b1;
						result_d.status = STATUS_OK;
					end else if (count_q < CW'(TABLE_ENTRIES)) begin
						mem_we          = 1'b1;
						mem_waddr       = count_q[IW-1:0];
						count_inc       = 1'b1;
						result_d.status = STATUS_OK;
					end else begin
						result_d.status = STATUS_FULL;
					end
				end else if (ip_seen_q) begin
					if (exact_hit_q) begin
						result_d = '{status: STATUS_OK, result_ip: exact_tgt_q.ip,
							result_port: exact_tgt_q.port};
					end else if (anyport_hit_q) begin
						result_d = '{status: STATUS_OK, result_ip: anyport_tgt_q.ip,
							result_port: anyport_tgt_q.port};
					end
				end else if (anyip_hit_q) begin
					result_d = '{status: STATUS_OK, result_ip: anyip_tgt_q.ip,
						result_port: anyip_tgt_q.port};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Only entries below the rule count hold rules.
	assign entry_vld = cmp_vld_s1 && (CW'(cmp_idx_s1) < count_q);

	// Control registers: state, read address, compare stage, rule count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			cmp_idx_s1 <= rd_idx_q;
			done_q     <= (state_q == ST_FINISH);
			if (accept) begin
				rd_idx_q <= '0;
			end else if (state_q == ST_SCAN && !last_read) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			if (count_inc) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Match flags, cleared when an item is accepted and set as entries stream by.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hit_q     <= 1'b0;
			ip_seen_q     <= 1'b0;
			exact_hit_q   <= 1'b0;
			anyport_hit_q <= 1'b0;
			anyip_hit_q   <= 1'b0;
		end else if (accept) begin
			key_hit_q     <= 1'b0;
			ip_seen_q     <= 1'b0;
			exact_hit_q   <= 1'b0;
			anyport_hit_q <= 1'b0;
			anyip_hit_q   <= 1'b0;
		end else if (entry_vld) begin
			if (req_q.action == ACT_MAP) begin
				if (rdata.ip_wild == req_q.key_ip_any && rdata.ip == req_q.key_ip &&
					rdata.port_wild == req_q.key_port_any &&
					rdata.port == req_q.key_port) begin
					key_hit_q <= 1'b1;
				end
			end else if (!rdata.ip_wild && rdata.ip == req_q.key_ip) begin
				ip_seen_q <= 1'b1;
				if (!rdata.port_wild && rdata.port == req_q.key_port) begin
					exact_hit_q <= 1'b1;
				end else if (rdata.port_wild) begin
					anyport_hit_q <= 1'b1;
				end
			end else if (rdata.ip_wild && !rdata.port_wild &&
				rdata.port == req_q.key_port) begin
				anyip_hit_q <= 1'b1;
			end
		end
	end

	// Payload registers: the item, hit index, captured targets and the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_norm;
		end
		if (entry_vld) begin
			if (req_q.action == ACT_MAP && rdata.ip_wild == req_q.key_ip_any &&
				rdata.ip == req_q.key_ip && rdata.port_wild == req_q.key_port_any &&
				rdata.port == req_q.key_port) begin
				hit_idx_q <= cmp_idx_s1;
			end
			if (!rdata.ip_wild && rdata.ip == req_q.key_ip) begin
				if (!rdata.port_wild && rdata.port == req_q.key_port) begin
					exact_tgt_q <= rdata.target;
				end else if (rdata.port_wild) begin
					anyport_tgt_q <= rdata.target;
				end
			end else if (rdata.ip_wild && !rdata.port_wild &&
				rdata.port == req_q.key_port) begin
				anyip_tgt_q <= rdata.target;
			end
		end
		if (state_q == ST_FINISH) begin
			result_q <= result_d;
		end
	end

endmodule

[sv/nwtt_rule_mem.sv]
module nwtt_rule_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  nwtt_pkg::nat_rule_t wdata,
	input  logic [AW-1:0]       raddr,
	output nwtt_pkg::nat_rule_t rdata
);
	import nwtt_pkg::*;

	nat_rule_t mem [DEPTH];
	nat_rule_t rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[bench/nat_table_checker.sv]
module nat_table_checker #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  nwtt_pkg::nat_req_t cmd,
	input  logic               done,
	input  nwtt_pkg::nat_rsp_t result,
	output int                 failures,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import nwtt_pkg::*;

	// Shadow copy of the rule table.
	nat_rule_t   rules [TABLE_ENTRIES];
	logic        rule_used [TABLE_ENTRIES];
	int unsigned rules_held;

	// Results predicted for accepted items, oldest first.
	nat_rsp_t    predicted_q [$];
	int          errors;

	// Applies one item to the shadow table and returns the result it should produce.
	function automatic nat_rsp_t apply_nat_item(input nat_req_t item);
		nat_rsp_t    rsp;
		logic [31:0] k_ip;
		logic [15:0] k_port;
		logic        ip_seen;
		logic        exact_hit;
		logic        anyport_hit;
		logic        anyip_hit;
		int          exact_idx;
		int          anyport_idx;
		int          anyip_idx;
		int          i;

		rsp = '0;
		rsp.status = STATUS_OK;
		if (item.action == ACT_MAP) begin
			// Wildcard key parts are kept as zero so that equal keys compare equal.
			k_ip = item.key_ip_any ? 32'd0 : item.key_ip;
			k_port = item.key_port_any ? 16'd0 : item.key_port;
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				if (rule_used[i] && rules[i].ip_wild == item.key_ip_any && rules[i].ip == k_ip &&
						rules[i].port_wild == item.key_port_any && rules[i].port == k_port) begin
					rules[i].target.ip = item.new_ip;
					rules[i].target.port = item.new_port;
					return rsp;
				end
			end
			if (rules_held >= TABLE_ENTRIES) begin
				rsp.status = STATUS_FULL;
				return rsp;
			end
			rule_used[rules_held] = 1'b1;
			rules[rules_held].ip = k_ip;
			rules[rules_held].ip_wild = item.key_ip_any;
			rules[rules_held].port = k_port;
			rules[rules_held].port_wild = item.key_port_any;
			rules[rules_held].target.ip = item.new_ip;
			rules[rules_held].target.port = item.new_port;
			rules_held++;
			return rsp;
		end

		// Translate: rules naming the ip take priority over any-ip rules.
		ip_seen = 1'b0;
		exact_hit = 1'b0;
		anyport_hit = 1'b0;
		anyip_hit = 1'b0;
		exact_idx = 0;
		anyport_idx = 0;
		anyip_idx = 0;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (rule_used[i]) begin
				if (!rules[i].ip_wild && rules[i].ip == item.key_ip) begin
					ip_seen = 1'b1;
					if (!rules[i].port_wild && rules[i].port == item.key_port) begin
						exact_hit = 1'b1;
						exact_idx = i;
					end else if (rules[i].port_wild) begin
						anyport_hit = 1'b1;
						anyport_idx = i;
					end
				end else if (rules[i].ip_wild && !rules[i].port_wild &&
						rules[i].port == item.key_port) begin
					anyip_hit = 1'b1;
					anyip_idx = i;
				end
			end
		end
		if (ip_seen && exact_hit) begin
			rsp.result_ip = rules[exact_idx].target.ip;
			rsp.result_port = rules[exact_idx].target.port;
		end else if (ip_seen && anyport_hit) begin
			rsp.result_ip = rules[anyport_idx].target.ip;
			rsp.result_port = rules[anyport_idx].target.port;
		end else if (!ip_seen && anyip_hit) begin
			rsp.result_ip = rules[anyip_idx].target.ip;
			rsp.result_port = rules[anyip_idx].target.port;
		end else begin
			rsp.status = STATUS_NOMATCH;
		end
		return rsp;
	endfunction

	// Compare each strobed result with the oldest prediction, then log new items.
	always @(posedge clk or negedge arst_n) begin
		nat_rsp_t want;

		if (!arst_n) begin
			predicted_q.delete();
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				rule_used[i] = 1'b0;
			end
			rules_held = 0;
			errors = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (predicted_q.size() == 0) begin
					$error("result with no item outstanding: status %0d ip %h port %h",
						result.status, result.result_ip, result.result_port);
					errors++;
				end else begin
					want = predicted_q.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						errors++;
					end
					if (result.result_ip !== want.result_ip) begin
						$error("result_ip: expected %h, got %h", want.result_ip, result.result_ip);
						errors++;
					end
					if (result.result_port !== want.result_port) begin
						$error("result_port: expected %h, got %h",
							want.result_port, result.result_port);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				predicted_q.push_back(apply_nat_item(cmd));
			end
			failures <= errors;
			pending <= predicted_q.size();
		end
	end

endmodule

[bench/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nwtt_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int ITEMS_PER_PHASE = 450;
	localparam int ADDR_POOL = 6;
	localparam int PORT_POOL = 8;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	nat_req_t cmd;
	logic     done;
	nat_rsp_t result;
	int       failures;
	int       pending;

	// Small sets of addresses and ports, so that keys repeat and lookups hit.
	logic [31:0] addr_pool [ADDR_POOL];
	logic [15:0] port_pool [PORT_POOL];

	nat_wildcard_translation_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	nat_table_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up if the run hangs.
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic nat_req_t map_item(input logic [31:0] ip, input logic ip_any,
			input logic [15:0] port, input logic port_any,
			input logic [31:0] to_ip, input logic [15:0] to_port);
		nat_req_t item;

		item.action = ACT_MAP;
		item.key_ip = ip;
		item.key_ip_any = ip_any;
		item.key_port = port;
		item.key_port_any = port_any;
		item.new_ip = to_ip;
		item.new_port = to_port;
		return item;
	endfunction

	// The wildcard flags and the target fields carry junk; a lookup ignores them.
	function automatic nat_req_t lookup_item(input logic [31:0] ip, input logic [15:0] port);
		nat_req_t item;

		item.action = ACT_XLATE;
		item.key_ip = ip;
		item.key_ip_any = 1'($urandom_range(1, 0));
		item.key_port = port;
		item.key_port_any = 1'($urandom_range(1, 0));
		item.new_ip = $urandom;
		item.new_port = 16'($urandom);
		return item;
	endfunction

	// Mostly pool keys with random wildcards; a few fully random keys fill the table.
	function automatic nat_req_t random_nat_item();
		logic [31:0] ip;
		logic [15:0] port;
		logic        ip_any;
		logic        port_any;

		ip = addr_pool[$urandom_range(ADDR_POOL - 1, 0)];
		port = port_pool[$urandom_range(PORT_POOL - 1, 0)];
		if ($urandom_range(99, 0) < 45) begin
			if ($urandom_range(9, 0) == 0) begin
				ip = $urandom;
				port = 16'($urandom);
			end
			ip_any = ($urandom_range(5, 0) == 0);
			port_any = ($urandom_range(4, 0) == 0);
			if (ip_any) begin
				ip = $urandom;
			end
			if (port_any) begin
				port = 16'($urandom);
			end
			return map_item(ip, ip_any, port, port_any, $urandom, 16'($urandom));
		end
		if ($urandom_range(4, 0) == 0) begin
			ip = $urandom;
		end
		if ($urandom_range(4, 0) == 0) begin
			port = 16'($urandom);
		end
		return lookup_item(ip, port);
	endfunction

	// Offers one item, after an optional gap, and returns at the edge that takes it.
	task automatic send_item(input nat_req_t item, input int unsigned idle_pct);
		if ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(80, 1)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= item;
		do @(posedge clk); while (busy);
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [31:0]  ip_a;
		logic [31:0]  ip_b;
		nat_req_t     directed [$];
		int unsigned  idle_pct [4];

		ip_a = 32'h0A00_0001;
		ip_b = 32'hC0A8_0102;
		idle_pct = '{0, 50, 11, 0};
		for (int i = 0; i < ADDR_POOL; i++) begin
			addr_pool[i] = $urandom;
		end
		for (int i = 0; i < PORT_POOL; i++) begin
			port_pool[i] = 16'($urandom);
		end

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lookup on the empty table, then the all-ones key and target.
		directed.push_back(lookup_item(32'd0, 16'd0));
		directed.push_back(map_item(32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b0,
			32'hFFFF_FFFF, 16'hFFFF));
		directed.push_back(lookup_item(32'hFFFF_FFFF, 16'hFFFF));
		// Any-ip rule, found for an address that no rule names.
		directed.push_back(map_item(32'hDEAD_BEEF, 1'b1, 16'd80, 1'b0, 32'h0101_0101, 16'd8080));
		directed.push_back(lookup_item(32'h0808_0808, 16'd80));
		// Any-port rule, then an exact rule for the same address.
		directed.push_back(map_item(ip_a, 1'b0, 16'h1234, 1'b1, 32'h0202_0202, 16'd443));
		directed.push_back(lookup_item(ip_a, 16'd9999));
		directed.push_back(map_item(ip_a, 1'b0, 16'd1234, 1'b0, 32'h0303_0303, 16'd1));
		directed.push_back(lookup_item(ip_a, 16'd1234));
		// A named address falls back to its any-port rule, not to the any-ip rule.
		directed.push_back(lookup_item(ip_a, 16'd80));
		// A named address without a matching port is no match, even with an any-ip rule.
		directed.push_back(map_item(ip_b, 1'b0, 16'd5, 1'b0, 32'h0404_0404, 16'd55));
		directed.push_back(lookup_item(ip_b, 16'd80));
		// An any-ip, any-port rule is stored but never hit.
		directed.push_back(map_item($urandom, 1'b1, 16'($urandom), 1'b1, 32'h0505_0505, 16'd5));
		directed.push_back(lookup_item(32'h0707_0707, 16'd7));
		// Update of an existing exact rule.
		directed.push_back(map_item(ip_a, 1'b0, 16'd1234, 1'b0, 32'hFFFF_0000, 16'd0));
		directed.push_back(lookup_item(ip_a, 16'd1234));
		// A wildcard key with a different value still updates the same rule.
		directed.push_back(map_item(32'h5555_AAAA, 1'b1, 16'd80, 1'b0, 32'd0, 16'd0));
		directed.push_back(lookup_item(32'h0909_0909, 16'd80));
		// Zero key as an exact value, then as a wildcard ip: two separate rules.
		directed.push_back(map_item(32'd0, 1'b0, 16'd0, 1'b0, 32'h0000_FFFF, 16'hFFFF));
		directed.push_back(lookup_item(32'd0, 16'd0));
		directed.push_back(map_item(32'd0, 1'b1, 16'd0, 1'b0, 32'h1111_2222, 16'h3333));
		directed.push_back(lookup_item(32'h1234_5678, 16'd0));

		foreach (directed[i]) begin
			send_item(directed[i], 0);
		end
		wait_drained();

		// Random phases with sender gaps of varying frequency; the table fills up along the way.
		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_item(random_nat_item(), idle_pct[phase]);
			end
			wait_drained();
		end

		repeat (TABLE_ENTRIES + 8) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/nwtt_pkg.sv
sv/nwtt_rule_mem.sv
sv/nat_wildcard_translation_table.sv
bench/nat_table_checker.sv
bench/testbench.sv
